// ----- rtl/text_console_character_engine_assert.svh -----
// Assertion macros, clocked on clk_i and disabled while rst_ni is low.
`ifndef TEXT_CONSOLE_CHARACTER_ENGINE_ASSERT_SVH
`define TEXT_CONSOLE_CHARACTER_ENGINE_ASSERT_SVH

// Same-cycle implication.
`define TCCE_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tcce assertion failed");

// Next-cycle implication.
`define TCCE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tcce assertion failed");

`endif

// ----- rtl/tcce_pkg.sv -----
`timescale 1ns / 1ps

package tcce_pkg;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  localparam logic [7:0] BLANK_CHAR   = 8'h20;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] RESET_ATTR   = 8'h0A;

endpackage

// ----- rtl/tcce_screen_ram.sv -----
`timescale 1ns / 1ps

module tcce_screen_ram #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [15:0]   wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [15:0]   rdata_o
);

  logic [15:0] mem [DEPTH];
  logic [15:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/text_console_character_engine.sv -----
`timescale 1ns / 1ps

// Text console engine over a COLUMNS x ROWS screen of 16-bit cells (attribute in the
// high byte, character in the low byte) held in one synchronous RAM with a registered
// read. A printable character, backspace, a newline that does not scroll, and an unused
// op finish straight from idle; a cell read goes through ST_READ for the RAM read. A
// newline or wrap past the bottom row scrolls: the copy loop moves each cell up one row,
// then the bottom row is blanked. A clear writes every cell. After reset the RAM is swept
// to blanks in attribute 0x0A, one cell per cycle, with no input taken; attribute writes
// are taken throughout. A finished result sits in an output register, and the next item
// is taken while it waits.
module text_console_character_engine #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [7:0]  char_code_i,
  input  logic        end_of_print_i,
  input  logic [10:0] cell_address_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] cell_data_o,
  output logic [10:0] cursor_position_o,
  output logic        cursor_load_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i
);

  import tcce_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);
  localparam int PW    = (AW > 11) ? AW : 11;

  localparam logic [AW-1:0] LAST_CELL   = AW'(CELLS - 1);
  localparam logic [AW-1:0] COPY_LAST   = AW'((ROWS - 1) * COLUMNS - 1);
  localparam logic [AW-1:0] BLANK_FIRST = AW'((ROWS - 1) * COLUMNS);
  localparam logic [AW-1:0] ROW_STRIDE  = AW'(COLUMNS);
  localparam logic [CW-1:0] COL_LAST    = CW'(COLUMNS - 1);
  localparam logic [RW-1:0] ROW_LAST    = RW'(ROWS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_BLANK,
    ST_CLEAR,
    ST_EMIT
  } state_e;

  state_e        state_q, state_d;
  logic [AW-1:0] ptr_q, ptr_d;
  logic          cp_valid_q, cp_valid_d;
  logic [AW-1:0] cp_addr_q, cp_addr_d;
  logic          sweep_q, sweep_d;
  logic [7:0]    attr_q, attr_d;
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic          addr_ok_q, addr_ok_d;
  logic          res_load_q, res_load_d;
  logic [15:0]   res_data_q, res_data_d;
  logic          out_valid_q, out_valid_d;
  logic [15:0]   cell_data_q, cell_data_d;
  logic [10:0]   cursor_position_q, cursor_position_d;
  logic          cursor_load_q, cursor_load_d;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [15:0]   ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [15:0]   ram_rdata;

  logic          in_fire;
  logic          out_free;
  logic          finish;
  logic          scroll;
  logic [15:0]   fin_data;
  logic          fin_load;
  logic [7:0]    fill_attr;
  logic [AW-1:0] cur_pos;
  logic [AW-1:0] nxt_pos;
  logic [PW-1:0] pos_wide;

  tcce_screen_ram #(
    .DEPTH(CELLS),
    .AW   (AW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign fill_attr   = sweep_q ? RESET_ATTR : attr_q;
  assign cur_pos     = AW'(row_q) * ROW_STRIDE + AW'(col_q);
  assign nxt_pos     = AW'(row_d) * ROW_STRIDE + AW'(col_d);
  assign pos_wide    = PW'(nxt_pos);

  always_comb begin
    state_d           = state_q;
    ptr_d             = ptr_q;
    cp_valid_d        = 1'b0;
    cp_addr_d         = ptr_q;
    sweep_d           = sweep_q;
    attr_d            = attr_q;
    col_d             = col_q;
    row_d             = row_q;
    addr_ok_d         = addr_ok_q;
    res_load_d        = res_load_q;
    res_data_d        = res_data_q;
    out_valid_d       = out_valid_q && !out_ready_i;
    cell_data_d       = cell_data_q;
    cursor_position_d = cursor_position_q;
    cursor_load_d     = cursor_load_q;

    ram_we    = cp_valid_q;
    ram_waddr = cp_addr_q;
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = ptr_q + ROW_STRIDE;

    finish   = 1'b0;
    scroll   = 1'b0;
    fin_data = 16'h0000;
    fin_load = res_load_q;

    if (cfg_valid_i) begin
      attr_d = cfg_data_i;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (op_i)
            OP_PUT: begin
              fin_load   = end_of_print_i;
              res_load_d = end_of_print_i;
              if (char_code_i == CH_NEWLINE) begin
                col_d = '0;
                if (row_q == ROW_LAST) begin
                  scroll = 1'b1;
                end else begin
                  row_d = row_q + 1'b1;
                end
              end else if (char_code_i == CH_BACKSPACE) begin
                if (col_q != '0) begin
                  col_d = col_q - 1'b1;
                end else if (row_q != '0) begin
                  row_d = row_q - 1'b1;
                  col_d = COL_LAST;
                end
              end else begin
                ram_we    = 1'b1;
                ram_waddr = cur_pos;
                ram_wdata = {attr_q, char_code_i};
                if (col_q == COL_LAST) begin
                  col_d = '0;
                  if (row_q == ROW_LAST) begin
                    scroll = 1'b1;
                  end else begin
                    row_d = row_q + 1'b1;
                  end
                end else begin
                  col_d = col_q + 1'b1;
                end
              end
              if (scroll) begin
                state_d = ST_SCROLL;
                ptr_d   = '0;
              end else begin
                finish = 1'b1;
              end
            end
            OP_CLEAR: begin
              col_d      = '0;
              row_d      = '0;
              ptr_d      = '0;
              sweep_d    = 1'b0;
              res_load_d = 1'b1;
              state_d    = ST_CLEAR;
            end
            OP_READ: begin
              addr_ok_d  = ({21'b0, cell_address_i} < 32'(CELLS));
              ram_re     = addr_ok_d;
              ram_raddr  = AW'(cell_address_i);
              res_load_d = 1'b0;
              state_d    = ST_READ;
            end
            default: begin
              fin_load = 1'b0;
              finish   = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        finish   = 1'b1;
        fin_load = 1'b0;
        fin_data = addr_ok_q ? ram_rdata : 16'h0000;
      end
      ST_SCROLL: begin
        ram_re     = 1'b1;
        ram_raddr  = ptr_q + ROW_STRIDE;
        cp_valid_d = 1'b1;
        cp_addr_d  = ptr_q;
        if (ptr_q == COPY_LAST) begin
          ptr_d   = BLANK_FIRST;
          state_d = ST_BLANK;
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end
      ST_BLANK: begin
        if (!cp_valid_q) begin
          ram_we    = 1'b1;
          ram_waddr = ptr_q;
          ram_wdata = {attr_q, BLANK_CHAR};
          if (ptr_q == LAST_CELL) begin
            finish = 1'b1;
          end else begin
            ptr_d = ptr_q + 1'b1;
          end
        end
      end
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_q;
        ram_wdata = {fill_attr, BLANK_CHAR};
        if (ptr_q == LAST_CELL) begin
          if (sweep_q) begin
            sweep_d = 1'b0;
            state_d = ST_IDLE;
          end else begin
            finish = 1'b1;
          end
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end
      ST_EMIT: begin
        finish   = 1'b1;
        fin_data = res_data_q;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (finish) begin
      if (out_free) begin
        out_valid_d       = 1'b1;
        cell_data_d       = fin_data;
        cursor_position_d = pos_wide[10:0];
        cursor_load_d     = fin_load;
        state_d           = ST_IDLE;
      end else begin
        res_data_d = fin_data;
        res_load_d = fin_load;
        state_d    = ST_EMIT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q           <= ST_CLEAR;
      ptr_q             <= '0;
      cp_valid_q        <= 1'b0;
      cp_addr_q         <= '0;
      sweep_q           <= 1'b1;
      attr_q            <= RESET_ATTR;
      col_q             <= '0;
      row_q             <= '0;
      addr_ok_q         <= 1'b0;
      res_load_q        <= 1'b0;
      res_data_q        <= '0;
      out_valid_q       <= 1'b0;
      cell_data_q       <= '0;
      cursor_position_q <= '0;
      cursor_load_q     <= 1'b0;
    end else begin
      state_q           <= state_d;
      ptr_q             <= ptr_d;
      cp_valid_q        <= cp_valid_d;
      cp_addr_q         <= cp_addr_d;
      sweep_q           <= sweep_d;
      attr_q            <= attr_d;
      col_q             <= col_d;
      row_q             <= row_d;
      addr_ok_q         <= addr_ok_d;
      res_load_q        <= res_load_d;
      res_data_q        <= res_data_d;
      out_valid_q       <= out_valid_d;
      cell_data_q       <= cell_data_d;
      cursor_position_q <= cursor_position_d;
      cursor_load_q     <= cursor_load_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign cell_data_o       = cell_data_q;
  assign cursor_position_o = cursor_position_q;
  assign cursor_load_o     = cursor_load_q;

endmodule

// ----- rtl/tcce_checker.sv -----
`timescale 1ns / 1ps
`include "text_console_character_engine_assert.svh"

module tcce_checker #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [1:0]  op_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] cell_data_o,
  input logic [10:0] cursor_position_o,
  input logic        cursor_load_o
);

  import tcce_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;

  logic [27:0] out_payload;

  assign out_payload = {cell_data_o, cursor_position_o, cursor_load_o};

  `TCCE_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_payload))
  `TCCE_ASSERT_SAME(a_load_no_data, out_valid_o && cursor_load_o, cell_data_o == 16'h0000)
  `TCCE_ASSERT_SAME(a_pos_range, out_valid_o, 32'(cursor_position_o) < CELLS)
  `TCCE_ASSERT_NEXT(a_clear_stalls, in_valid_i && in_ready_o && (op_i == OP_CLEAR), !in_ready_o)

endmodule

bind text_console_character_engine tcce_checker #(
  .COLUMNS(COLUMNS),
  .ROWS   (ROWS)
) u_tcce_checker (.*);
